// File: hdl/dba_pkg.sv
// shared types and constants for the debounced button actuator control block
package dba_pkg;

  // fixed field and register widths
  localparam int DEBOUNCE_W = 10;
  localparam int DUR_W      = 16;
  localparam int STEADY_W   = 11;
  localparam int AGE_W      = 16;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  // widest button vector, used to index action bits at fixed positions
  localparam int PAD_W      = 16;

  // button positions that drive actuators
  localparam int GATE_BTN   = 3;
  localparam int PUMP_BTN   = 4;
  localparam int FAN_BTN    = 5;
  localparam int FEEDER_BTN = 6;

  // saturation limits
  localparam logic [STEADY_W-1:0] STEADY_MAX = '1;
  localparam logic [AGE_W-1:0]    AGE_MAX    = '1;

  // register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd50;
  localparam logic [DUR_W-1:0]      PUMP_RST     = 16'd3500;
  localparam logic [DUR_W-1:0]      FEEDER_RST   = 16'd2500;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PUMP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FEEDER   = 2'd2;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_CMD  = 1'b1
  } func_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_GATE   = 2'd0,
    CMD_PUMP   = 2'd1,
    CMD_FAN    = 2'd2,
    CMD_FEEDER = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [DUR_W-1:0]      pump_ms;
    logic [DUR_W-1:0]      feeder_ms;
  } cfg_t;

  typedef struct packed {
    logic gate_bit;
    logic fan_bit;
    logic pump_on;
    logic feeder_on;
  } act_t;

endpackage

// File: hdl/dba_if.sv
// item channel interfaces for the input and result sides
interface dba_in_if #(
  parameter int BUTTON_COUNT = 7
);
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [BUTTON_COUNT-1:0] raw_buttons;
  logic [1:0]              command;

  modport source (output valid, output func, output raw_buttons, output command,
                  input ready);
  modport sink   (input valid, input func, input raw_buttons, input command,
                  output ready);
endinterface

interface dba_out_if #(
  parameter int BUTTON_COUNT = 7
);
  logic                    valid;
  logic                    ready;
  logic [BUTTON_COUNT-1:0] stable_buttons;
  logic [BUTTON_COUNT-1:0] pressed_mask;
  logic                    gate_bit;
  logic                    fan_bit;
  logic                    pump_on;
  logic                    feeder_on;

  modport source (output valid, output stable_buttons, output pressed_mask,
                  output gate_bit, output fan_bit, output pump_on, output feeder_on,
                  input ready);
  modport sink   (input valid, input stable_buttons, input pressed_mask,
                  input gate_bit, input fan_bit, input pump_on, input feeder_on,
                  output ready);
endinterface

// File: hdl/debounced_button_actuator_control_core.sv
// top level: button debounce with gate/fan toggles and pump/feeder one-shots
//
// Input channel in_ch carries one item per handshake: a millisecond tick with
// a raw active-low button sample (func 0) or a direct command (func 1,
// command 0 gate toggle, 1 pump start, 2 fan toggle, 3 feeder start).
// Result channel out_ch returns exactly one item per input item: the stable
// button set, the newly pressed mask and the four actuator bits.
// Throughput is one item per clock unless the result buffer is full; each
// item is handled by a single pass of debounce/timer logic whose result is
// registered in the result buffer. The state registers feed that pass
// directly, so back-to-back items see each other's updates.
// A two-entry result buffer lets one more item in while a result waits; with
// both entries full in_ch.ready drops until out_ch.ready takes a result.
// Synchronous active-low reset clears the buffer, loads debounce 50, pump
// 3500 and feeder 2500 ticks, sets all buttons released, gate and fan set
// to 1 and both timers stopped. Registers are written through cfg_we/cfg_index/
// cfg_wdata, one per clock, and should only change while the block is idle.
module debounced_button_actuator_control_core
  import dba_pkg::*;
#(
  parameter int BUTTON_COUNT = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dba_in_if.sink                in_ch,
  dba_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RES_W = 2 * BUTTON_COUNT + 4;

  cfg_t                    cfg;
  logic                    acc;
  logic                    buf_ready;
  logic [BUTTON_COUNT-1:0] res_stable;
  logic [BUTTON_COUNT-1:0] res_pressed;
  act_t                    res_act;
  logic [RES_W-1:0]        res_data;
  logic [RES_W-1:0]        out_data;

  // configuration registers
  dba_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  assign in_ch.ready = buf_ready;
  assign acc         = in_ch.valid && buf_ready;

  // per-item state update
  dba_step_unit #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc_i         (acc),
    .func_i        (in_ch.func),
    .raw_i         (in_ch.raw_buttons),
    .cmd_i         (in_ch.command),
    .cfg_i         (cfg),
    .res_stable_o  (res_stable),
    .res_pressed_o (res_pressed),
    .res_act_o     (res_act)
  );

  assign res_data = {res_stable, res_pressed, res_act};

  // result buffer
  dba_out_buf #(
    .DATA_W (RES_W)
  ) u_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (buf_ready),
    .in_data_i   (res_data),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_o  (out_data)
  );

  // unpack the result item
  assign out_ch.stable_buttons = out_data[RES_W-1 -: BUTTON_COUNT];
  assign out_ch.pressed_mask   = out_data[RES_W-BUTTON_COUNT-1 -: BUTTON_COUNT];
  assign out_ch.gate_bit       = out_data[3];
  assign out_ch.fan_bit        = out_data[2];
  assign out_ch.pump_on        = out_data[1];
  assign out_ch.feeder_on      = out_data[0];

endmodule

// File: hdl/dba_cfg_regs.sv
// configuration registers: debounce time and one-shot durations
module dba_cfg_regs
  import dba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;

  // indexed write, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= DEBOUNCE_RST;
      cfg_r.pump_ms     <= PUMP_RST;
      cfg_r.feeder_ms   <= FEEDER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_DEBOUNCE: cfg_r.debounce_ms <= cfg_wdata[DEBOUNCE_W-1:0];
        CFG_IDX_PUMP:     cfg_r.pump_ms     <= cfg_wdata[DUR_W-1:0];
        CFG_IDX_FEEDER:   cfg_r.feeder_ms   <= cfg_wdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: hdl/dba_step_unit.sv
// per-item state update: debounce, edge actions and one-shot timers
module dba_step_unit
  import dba_pkg::*;
#(
  parameter int BUTTON_COUNT = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc_i,
  input  logic                    func_i,
  input  logic [BUTTON_COUNT-1:0] raw_i,
  input  logic [CMD_W-1:0]        cmd_i,
  input  cfg_t                    cfg_i,
  output logic [BUTTON_COUNT-1:0] res_stable_o,
  output logic [BUTTON_COUNT-1:0] res_pressed_o,
  output act_t                    res_act_o
);

  logic [BUTTON_COUNT-1:0] last_raw_r, last_raw_nxt;
  logic [BUTTON_COUNT-1:0] stable_r, stable_nxt;
  logic [STEADY_W-1:0]     steady_r, steady_nxt;
  logic                    gate_r, gate_nxt;
  logic                    fan_r, fan_nxt;
  logic                    pump_run_r, pump_run_nxt;
  logic [AGE_W-1:0]        pump_age_r, pump_age_nxt;
  logic                    feeder_run_r, feeder_run_nxt;
  logic [AGE_W-1:0]        feeder_age_r, feeder_age_nxt;
  logic [BUTTON_COUNT-1:0] pressed;
  logic [PAD_W-1:0]        pressed_pad;
  logic                    take_set;

  // next state for one item
  always_comb begin
    last_raw_nxt   = last_raw_r;
    stable_nxt     = stable_r;
    steady_nxt     = steady_r;
    gate_nxt       = gate_r;
    fan_nxt        = fan_r;
    pump_run_nxt   = pump_run_r;
    pump_age_nxt   = pump_age_r;
    feeder_run_nxt = feeder_run_r;
    feeder_age_nxt = feeder_age_r;
    pressed        = '0;
    pressed_pad    = '0;
    take_set       = 1'b0;

    if (func_i == FUNC_TICK) begin
      // running timers age by one
      if (pump_run_r && pump_age_r != AGE_MAX) pump_age_nxt = pump_age_r + 1'b1;
      if (feeder_run_r && feeder_age_r != AGE_MAX) feeder_age_nxt = feeder_age_r + 1'b1;

      // debounce age restarts on a changed sample
      if (raw_i != last_raw_r) begin
        last_raw_nxt = raw_i;
        steady_nxt   = '0;
      end else if (steady_r != STEADY_MAX) begin
        steady_nxt = steady_r + 1'b1;
      end

      // accept a steady new set and act on its falling edges
      take_set = (steady_nxt >= STEADY_W'(cfg_i.debounce_ms)) && (stable_r != raw_i);
      if (take_set) begin
        pressed     = stable_r & ~raw_i;
        pressed_pad = PAD_W'(pressed);
        stable_nxt  = raw_i;
        if (pressed_pad[GATE_BTN]) gate_nxt = ~gate_r;
        if (pressed_pad[FAN_BTN])  fan_nxt  = ~fan_r;
        if (pressed_pad[PUMP_BTN] && !pump_run_r) begin
          pump_run_nxt = 1'b1;
          pump_age_nxt = '0;
        end
        if (pressed_pad[FEEDER_BTN] && !feeder_run_r) begin
          feeder_run_nxt = 1'b1;
          feeder_age_nxt = '0;
        end
      end

      // stop timers that reached their duration
      if (pump_run_nxt && pump_age_nxt >= cfg_i.pump_ms) pump_run_nxt = 1'b0;
      if (feeder_run_nxt && feeder_age_nxt >= cfg_i.feeder_ms) feeder_run_nxt = 1'b0;
    end else begin
      case (cmd_t'(cmd_i))
        CMD_GATE: gate_nxt = ~gate_r;
        CMD_PUMP: begin
          if (!pump_run_r) begin
            pump_run_nxt = 1'b1;
            pump_age_nxt = '0;
          end
        end
        CMD_FAN: fan_nxt = ~fan_r;
        CMD_FEEDER: begin
          if (!feeder_run_r) begin
            feeder_run_nxt = 1'b1;
            feeder_age_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // state registers, updated once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r   <= '1;
      stable_r     <= '1;
      steady_r     <= '0;
      gate_r       <= 1'b1;
      fan_r        <= 1'b1;
      pump_run_r   <= 1'b0;
      pump_age_r   <= '0;
      feeder_run_r <= 1'b0;
      feeder_age_r <= '0;
    end else if (acc_i) begin
      last_raw_r   <= last_raw_nxt;
      stable_r     <= stable_nxt;
      steady_r     <= steady_nxt;
      gate_r       <= gate_nxt;
      fan_r        <= fan_nxt;
      pump_run_r   <= pump_run_nxt;
      pump_age_r   <= pump_age_nxt;
      feeder_run_r <= feeder_run_nxt;
      feeder_age_r <= feeder_age_nxt;
    end
  end

  // result of this item
  assign res_stable_o        = stable_nxt;
  assign res_pressed_o       = pressed;
  assign res_act_o.gate_bit  = gate_nxt;
  assign res_act_o.fan_bit   = fan_nxt;
  assign res_act_o.pump_on   = pump_run_nxt;
  assign res_act_o.feeder_on = feeder_run_nxt;

  // a command never moves the button state
  a_cmd_keeps_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && func_i == FUNC_CMD) |=> ($stable(stable_r) && $stable(last_raw_r)))
    else $error("command changed button state");

  // an accepted change leaves the stable set equal to the sample
  a_take_set: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && take_set) |=> (stable_r == $past(raw_i)))
    else $error("accepted set does not match sample");

  // actuator bits only move on an accepted item
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !acc_i |=> ($stable(gate_r) && $stable(fan_r) && $stable(pump_run_r)
                && $stable(feeder_run_r)))
    else $error("state moved without an item");

endmodule

// File: hdl/dba_out_buf.sv
// two-entry result buffer so input keeps flowing while a result waits
module dba_out_buf #(
  parameter int DATA_W = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              skid_valid_r;
  logic [DATA_W-1:0] skid_data_r;
  logic              push;
  logic              out_free;

  assign in_ready_o = !skid_valid_r;
  assign push       = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_r || out_ready_i;

  // control: main slot refills from skid first, else from input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_data_i;
    end else if (push) begin
      skid_data_r <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

  // skid slot is only filled behind a held main slot
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full with main slot empty");

  // skid fills only when the main slot stalls
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready_i))
    else $error("skid filled without a stall");

  // a waiting skid item moves up when the main slot drains
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready_i) |=> (out_valid_r && !skid_valid_r))
    else $error("skid item not moved up");

endmodule

// File: tb/testbench.sv
// self-checking testbench for the debounced button actuator control core
module testbench
  import dba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BTNS         = 7;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 4;

  typedef struct {
    func_t           func;
    logic [BTNS-1:0] raw;
    cmd_t            cmd;
  } panel_item_t;

  typedef struct packed {
    logic [BTNS-1:0] stable;
    logic [BTNS-1:0] pressed;
    logic            gate;
    logic            fan;
    logic            pump;
    logic            feeder;
  } panel_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dba_in_if  #(.BUTTON_COUNT(BTNS)) in_ch ();
  dba_out_if #(.BUTTON_COUNT(BTNS)) out_ch ();

  debounced_button_actuator_control_core #(.BUTTON_COUNT(BTNS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the panel registers and state
  logic [DEBOUNCE_W-1:0] dbc_ms;
  logic [DUR_W-1:0]      pump_ms;
  logic [DUR_W-1:0]      feeder_ms;
  logic [BTNS-1:0]       held_raw;
  logic [BTNS-1:0]       accepted_set;
  logic [STEADY_W-1:0]   steady_age;
  logic                  gate_bit;
  logic                  fan_bit;
  logic                  pump_run;
  logic [AGE_W-1:0]      pump_age;
  logic                  feeder_run;
  logic [AGE_W-1:0]      feeder_age;

  // stimulus side bookkeeping
  panel_item_t     item_backlog[$];
  panel_status_t   status_due[$];
  logic [BTNS-1:0] gen_raw;
  int              n_pushed;
  int              n_issued;
  int              n_results;
  int              n_errors;
  int              cycle_count;

  // handshake side state
  bit in_taken;
  bit out_taken;
  bit offering;
  bit in_burst;
  bit out_burst;
  int gap_left;
  int stall_left;
  int hold_left;
  int hold_mark = 400;

  // advance the panel by one item and return the status it reports
  function automatic panel_status_t advance_panel(panel_item_t it);
    logic [BTNS-1:0] newly;
    panel_status_t   st;
    newly = '0;
    if (it.func == FUNC_TICK) begin
      if (pump_run && pump_age != AGE_MAX) pump_age++;
      if (feeder_run && feeder_age != AGE_MAX) feeder_age++;
      // debounce age restarts on any change of the sample
      if (it.raw != held_raw) begin
        held_raw   = it.raw;
        steady_age = '0;
      end else if (steady_age != STEADY_MAX) begin
        steady_age++;
      end
      // accept a steady new set and act on its falling edges
      if (steady_age >= dbc_ms && accepted_set != it.raw) begin
        newly = accepted_set & ~it.raw;
        if (newly[GATE_BTN]) gate_bit = ~gate_bit;
        if (newly[FAN_BTN]) fan_bit = ~fan_bit;
        if (newly[PUMP_BTN] && !pump_run) begin
          pump_run = 1'b1;
          pump_age = '0;
        end
        if (newly[FEEDER_BTN] && !feeder_run) begin
          feeder_run = 1'b1;
          feeder_age = '0;
        end
        accepted_set = it.raw;
      end
      // one-shots stop once their age reaches the current duration
      if (pump_run && pump_age >= pump_ms) pump_run = 1'b0;
      if (feeder_run && feeder_age >= feeder_ms) feeder_run = 1'b0;
    end else begin
      case (it.cmd)
        CMD_GATE: gate_bit = ~gate_bit;
        CMD_FAN:  fan_bit = ~fan_bit;
        CMD_PUMP: begin
          if (!pump_run) begin
            pump_run = 1'b1;
            pump_age = '0;
          end
        end
        default: begin
          if (!feeder_run) begin
            feeder_run = 1'b1;
            feeder_age = '0;
          end
        end
      endcase
    end
    st.stable  = accepted_set;
    st.pressed = newly;
    st.gate    = gate_bit;
    st.fan     = fan_bit;
    st.pump    = pump_run;
    st.feeder  = feeder_run;
    return st;
  endfunction

  // per-item wait, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic push_tick(logic [BTNS-1:0] raw);
    panel_item_t it;
    it.func = FUNC_TICK;
    it.raw  = raw;
    it.cmd  = cmd_t'($urandom_range(0, 3));
    item_backlog.push_back(it);
    gen_raw = raw;
    n_pushed++;
  endtask

  task automatic push_cmd(cmd_t c);
    panel_item_t it;
    it.func = FUNC_CMD;
    it.raw  = BTNS'($urandom_range(0, 127));
    it.cmd  = c;
    item_backlog.push_back(it);
    n_pushed++;
  endtask

  // one button change: optional bounce, then a hold that usually outlasts the debounce
  task automatic push_sequence();
    logic [BTNS-1:0] target;
    logic [BTNS-1:0] prior;
    int              bounces;
    int              hold;
    prior = gen_raw;
    case ($urandom_range(0, 5))
      0, 1, 2: target = gen_raw ^ (BTNS'(1) << $urandom_range(0, BTNS - 1));
      3:       target = gen_raw ^ BTNS'($urandom_range(1, 127));
      4:       target = BTNS'($urandom_range(0, 127));
      default: begin
        // noise
        repeat ($urandom_range(1, 4)) push_tick(BTNS'($urandom_range(0, 127)));
        target = gen_raw;
      end
    endcase
    bounces = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    for (int i = 0; i < bounces; i++) push_tick((i % 2 == 0) ? target : prior);
    if (dbc_ms > 12) hold = $urandom_range(1, 6);
    else if ($urandom_range(0, 5) == 0) hold = dbc_ms;  // released one tick too early
    else hold = dbc_ms + 1 + $urandom_range(0, 3);
    repeat (hold) begin
      if ($urandom_range(0, 15) == 0) push_cmd(cmd_t'($urandom_range(0, 3)));
      push_tick(target);
    end
    if ($urandom_range(0, 5) == 0) push_cmd(cmd_t'($urandom_range(0, 3)));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_IDX_DEBOUNCE: dbc_ms = value[DEBOUNCE_W-1:0];
      CFG_IDX_PUMP:     pump_ms = value;
      CFG_IDX_FEEDER:   feeder_ms = value;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // every queued item has produced its result, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk); while (n_results != n_pushed);
    repeat (SETTLE) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    panel_item_t it;
    if (in_taken) begin
      in_taken = 1'b0;
      offering = 1'b0;
      gap_left = draw_wait(in_burst);
    end
    if (!offering) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (item_backlog.size() > 0) begin
        it = item_backlog.pop_front();
        in_ch.func        <= it.func;
        in_ch.raw_buttons <= it.raw;
        in_ch.command     <= it.cmd;
        offering = 1'b1;
        n_issued++;
      end
    end
    in_ch.valid <= offering;
  end

  // long receiver hold-off so the result buffer fills and the input stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (n_issued >= hold_mark) begin
      hold_left = HOLD_CYCLES;
      hold_mark += 900;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken  = 1'b0;
      stall_left = draw_wait(out_burst);
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: check results first, then predict for the item accepted at this edge
  always @(posedge clk) begin
    panel_status_t got;
    panel_status_t want;
    panel_item_t   it;
    if (rst_n === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.stable  = out_ch.stable_buttons;
        got.pressed = out_ch.pressed_mask;
        got.gate    = out_ch.gate_bit;
        got.fan     = out_ch.fan_bit;
        got.pump    = out_ch.pump_on;
        got.feeder  = out_ch.feeder_on;
        n_results++;
        out_taken = 1'b1;
        if (status_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %0d: got %p", n_results, got);
        end else begin
          want = status_due.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d mismatch: expected %p, got %p", n_results, want, got);
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        it.func = func_t'(in_ch.func);
        it.raw  = in_ch.raw_buttons;
        it.cmd  = cmd_t'(in_ch.command);
        status_due.push_back(advance_panel(it));
        in_taken = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int  base;
    int  phase_len;
    int  mark;
    bit  extreme;
    logic [CFG_DATA_W-1:0] v;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_IDX_DEBOUNCE;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_TICK;
    in_ch.raw_buttons = '1;
    in_ch.command     = CMD_GATE;
    out_ch.ready      = 1'b0;

    dbc_ms       = DEBOUNCE_RST;
    pump_ms      = PUMP_RST;
    feeder_ms    = FEEDER_RST;
    held_raw     = '1;
    accepted_set = '1;
    steady_age   = '0;
    gate_bit     = 1'b1;
    fan_bit      = 1'b1;
    pump_run     = 1'b0;
    pump_age     = '0;
    feeder_run   = 1'b0;
    feeder_age   = '0;
    gen_raw      = '1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset durations: every command, repeated starts ignored, extreme samples
    push_cmd(CMD_GATE);
    push_cmd(CMD_FAN);
    push_cmd(CMD_PUMP);
    push_cmd(CMD_PUMP);
    push_cmd(CMD_FEEDER);
    push_cmd(CMD_FEEDER);
    push_tick(7'h00);
    push_tick(7'h7f);
    push_tick(7'h55);
    push_tick(7'h2a);
    wait_idle();

    // zero debounce and zero durations, shortened while both timers run
    write_reg(CFG_IDX_DEBOUNCE, 16'd0);
    write_reg(CFG_IDX_PUMP, 16'd0);
    write_reg(CFG_IDX_FEEDER, 16'd0);
    end_writes();
    push_tick(7'h2a);
    push_tick(7'h7f);
    push_tick(7'h00);
    push_tick(7'h7f);
    push_cmd(CMD_PUMP);
    push_tick(7'h7f);
    push_cmd(CMD_FEEDER);
    push_tick(7'h7f);
    wait_idle();

    // pump pressed through the debounce, then its duration cut while running
    write_reg(CFG_IDX_DEBOUNCE, 16'd2);
    write_reg(CFG_IDX_PUMP, 16'd1000);
    end_writes();
    repeat (3) push_tick(7'h6f);
    push_cmd(CMD_FEEDER);
    push_tick(7'h6f);
    wait_idle();
    write_reg(CFG_IDX_PUMP, 16'd1);
    end_writes();
    push_tick(7'h7f);
    wait_idle();

    // random phases, the first with every register at its top value
    base    = n_pushed;
    extreme = 1'b1;
    while (n_pushed - base < RANDOM_ITEMS) begin
      if (extreme) begin
        write_reg(CFG_IDX_DEBOUNCE, 16'd1023);
        write_reg(CFG_IDX_PUMP, 16'hffff);
        write_reg(CFG_IDX_FEEDER, 16'hffff);
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 9))
            0:       v = 16'd0;
            1:       v = 16'($urandom_range(13, 1023));
            default: v = 16'($urandom_range(1, 8));
          endcase
          write_reg(CFG_IDX_DEBOUNCE, v);
        end
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 9))
            0:       v = 16'd0;
            1:       v = 16'd1;
            2:       v = 16'($urandom_range(100, 600));
            default: v = 16'($urandom_range(2, 40));
          endcase
          write_reg(CFG_IDX_PUMP, v);
        end
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 9))
            0:       v = 16'd0;
            1:       v = 16'd1;
            2:       v = 16'($urandom_range(100, 600));
            default: v = 16'($urandom_range(2, 40));
          endcase
          write_reg(CFG_IDX_FEEDER, v);
        end
      end
      end_writes();
      phase_len = extreme ? 40 : $urandom_range(60, 180);
      extreme   = 1'b0;
      mark      = n_pushed;
      while (n_pushed - mark < phase_len) push_sequence();
      wait_idle();
    end

    if (n_errors == 0 && status_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/dba_pkg.sv
hdl/dba_if.sv
hdl/dba_cfg_regs.sv
hdl/dba_step_unit.sv
hdl/dba_out_buf.sv
hdl/debounced_button_actuator_control_core.sv
tb/testbench.sv
